### hdl/bss_pkg.sv
package bss_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int COUNT_W         = 31;
  localparam int BYTE_W          = 8;
  localparam int OPCODE_W        = 2;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FEED   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd3;

  typedef struct packed {
    logic              feed;
    logic              restart;
    logic              append;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

endpackage

### hdl/bss_cell.sv
module bss_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bss_pkg::cell_ctrl_t ctrl,
  input  logic [LEN_W-1:0]    len,
  input  logic                prev_match,
  output logic                match,
  output logic                hit
);

  logic [bss_pkg::BYTE_W-1:0] pat_r;
  logic                       match_r;
  logic                       match_nxt;
  logic                       active;
  logic                       last;

  assign active = LEN_W'(IDX) < len;
  assign last   = LEN_W'(IDX + 1) == len;

  always_comb begin
    match_nxt = match_r;
    if (ctrl.restart) begin
      match_nxt = 1'b0;
    end else if (ctrl.feed && active) begin
      match_nxt = prev_match && (pat_r == ctrl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && (len == LEN_W'(IDX))) begin
      pat_r <= ctrl.data;
    end
  end

  assign match = match_r;
  assign hit   = match_r & last;

endmodule

### hdl/byte_substring_search.sv
// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     tdata: opcode, data_byte
// out_     master     out_tvalid / out_tready   tdata: found, position, pattern_overflow
//
// One transaction per cycle on the input, every opcode; each pattern cell
// compares its byte with the haystack byte in the cycle it arrives.
// A finish gives its result in the cycle after acceptance, through the output register.
// The input stalls only while that register is full and out_tready is low.
// Reset (rst_n low, synchronous) empties the pattern and the output register.
module byte_substring_search #(
  parameter int MAX_PATTERN = bss_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bss_pkg::IN_TDATA_W-1:0]   in_tdata,   // [1:0] opcode, [9:2] data_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bss_pkg::OUT_TDATA_W-1:0]  out_tdata   // [0] found, [31:1] position,
                                                       // [32] pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [bss_pkg::OPCODE_W-1:0] opcode;
  logic [bss_pkg::BYTE_W-1:0]   data_byte;
  logic                         accept;
  bss_pkg::cell_ctrl_t          ctrl;

  logic [LEN_W-1:0]             len_r, len_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [bss_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bss_pkg::COUNT_W-1:0]  cnt_prev_r;
  logic                         seen_r, seen_nxt;
  logic [bss_pkg::COUNT_W-1:0]  pos_r;
  logic [bss_pkg::COUNT_W-1:0]  hit_pos;
  logic                         is_finish;

  logic [MAX_PATTERN-1:0]       match_vec;
  logic [MAX_PATTERN-1:0]       hit_vec;
  logic                         hit;

  logic                         out_valid_r;
  logic                         out_found_r;
  logic [bss_pkg::COUNT_W-1:0]  out_pos_r;
  logic                         out_ovf_r;
  logic                         res_found;
  logic [bss_pkg::COUNT_W-1:0]  res_pos;

  assign opcode    = in_tdata[bss_pkg::OPCODE_W-1:0];
  assign data_byte = in_tdata[bss_pkg::OPCODE_W +: bss_pkg::BYTE_W];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_finish = accept && (opcode == bss_pkg::OP_FINISH);

  always_comb begin
    ctrl.feed    = 1'b0;
    ctrl.restart = 1'b0;
    ctrl.append  = 1'b0;
    ctrl.data    = data_byte;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      unique case (opcode)
        bss_pkg::OP_CLEAR: begin
          ctrl.restart = 1'b1;
          len_nxt      = '0;
          ovf_nxt      = 1'b0;
        end
        bss_pkg::OP_APPEND: begin
          ctrl.restart = 1'b1;
          if (len_r < LEN_W'(MAX_PATTERN)) begin
            ctrl.append = 1'b1;
            len_nxt     = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        bss_pkg::OP_FEED: begin
          ctrl.feed = 1'b1;
        end
        bss_pkg::OP_FINISH: begin
          ctrl.restart = 1'b1;
        end
        default: begin
          ctrl.restart = 1'b0;
        end
      endcase
    end
  end

  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic prev;
      if (j == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = match_vec[j-1];
      end
      bss_cell #(
        .IDX   (j),
        .LEN_W (LEN_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .len        (len_r),
        .prev_match (prev),
        .match      (match_vec[j]),
        .hit        (hit_vec[j])
      );
    end
  endgenerate

  assign hit     = |hit_vec;
  assign hit_pos = cnt_prev_r - bss_pkg::COUNT_W'(len_r) + bss_pkg::COUNT_W'(1);

  always_comb begin
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    if (ctrl.restart) begin
      cnt_nxt  = '0;
      seen_nxt = 1'b0;
    end else begin
      if (ctrl.feed && (cnt_r != bss_pkg::COUNT_MAX)) begin
        cnt_nxt = cnt_r + bss_pkg::COUNT_W'(1);
      end
      if (hit) begin
        seen_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (len_r == '0) begin
      res_found = 1'b1;
      res_pos   = '0;
    end else if (seen_r) begin
      res_found = 1'b1;
      res_pos   = pos_r;
    end else if (hit) begin
      res_found = 1'b1;
      res_pos   = hit_pos;
    end else begin
      res_found = 1'b0;
      res_pos   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
      if (is_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.feed) begin
      cnt_prev_r <= cnt_r;
    end
    if (hit && !seen_r) begin
      pos_r <= hit_pos;
    end
    if (is_finish) begin
      out_found_r <= res_found;
      out_pos_r   <= res_pos;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bss_pkg::OUT_TDATA_W - bss_pkg::COUNT_W - 2){1'b0}},
                       out_ovf_r, out_pos_r, out_found_r};

endmodule

### bench/byte_substring_search_check.sv
module byte_substring_search_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bss_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              results_owed
);

  localparam int PAT_DEPTH = bss_pkg::MAX_PATTERN_DEF;

  typedef struct packed {
    logic                        found;
    logic [bss_pkg::COUNT_W-1:0] position;
    logic                        overflow;
  } search_result_t;

  logic [bss_pkg::BYTE_W-1:0]  pat_bytes [PAT_DEPTH];
  int                          pat_len;
  logic [PAT_DEPTH-1:0]        partial;
  logic [bss_pkg::COUNT_W-1:0] hay_count;
  logic                        match_seen;
  logic [bss_pkg::COUNT_W-1:0] match_pos;
  logic                        pat_overflow;
  search_result_t              result_q [$];
  int                          errors = 0;

  assign fail_count = errors;

  task rewind_haystack();
    partial    = '0;
    hay_count  = '0;
    match_seen = 1'b0;
    match_pos  = '0;
  endtask

  task search_step(input logic [bss_pkg::OPCODE_W-1:0] op,
                   input logic [bss_pkg::BYTE_W-1:0] b);
    search_result_t r;
    logic           prev;
    case (op)
      bss_pkg::OP_CLEAR: begin
        pat_len      = 0;
        pat_overflow = 1'b0;
        rewind_haystack();
      end
      bss_pkg::OP_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        rewind_haystack();
      end
      bss_pkg::OP_FEED: begin
        if (pat_len > 0) begin
          // walk downwards so each cell sees its neighbour's old value
          for (int j = pat_len - 1; j >= 0; j--) begin
            prev       = (j == 0) ? 1'b1 : partial[j-1];
            partial[j] = prev && (pat_bytes[j] == b);
          end
          if (partial[pat_len-1] && !match_seen) begin
            match_seen = 1'b1;
            match_pos  = hay_count - bss_pkg::COUNT_W'(pat_len - 1);
          end
        end
        if (hay_count != bss_pkg::COUNT_MAX)
          hay_count++;
      end
      default: begin
        r.found    = (pat_len == 0) || match_seen;
        r.position = (pat_len != 0 && match_seen) ? match_pos : '0;
        r.overflow = pat_overflow;
        result_q.push_back(r);
        rewind_haystack();
      end
    endcase
  endtask

  always @(posedge clk) begin
    search_result_t want;
    search_result_t got;
    got = {out_tdata[0], out_tdata[31:1], out_tdata[32]};
    if (!rst_n) begin
      pat_len      = 0;
      pat_overflow = 1'b0;
      rewind_haystack();
    end else begin
      if (in_tvalid && in_tready)
        search_step(in_tdata[1:0], in_tdata[9:2]);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %s%0d %s%0d %s%0d",
                   $time, "found=", got.found, "position=", got.position,
                   "overflow=", got.overflow);
        end else begin
          want = result_q.pop_front();
          if (got.found !== want.found) begin
            errors++;
            $display("%0t found: expected %0d actual %0d", $time, want.found, got.found);
          end
          if (got.position !== want.position) begin
            errors++;
            $display("%0t position: expected %0d actual %0d", $time, want.position,
                     got.position);
          end
          if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t pattern_overflow: expected %0d actual %0d", $time, want.overflow,
                     got.overflow);
          end
        end
      end
    end
    results_owed <= result_q.size();
  end

endmodule

### bench/byte_substring_search_tb.sv
module byte_substring_search_tb;

  localparam int ITEM_TARGET    = 2000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bss_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bss_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int results_owed;
  int sent = 0;
  int quiet_cycles = 0;
  bit burst = 1'b0;

  byte_substring_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  byte_substring_search_check i_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (burst)
      return 0;
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bss_pkg::BYTE_W-1:0] pick_byte(bit narrow,
                                                           logic [bss_pkg::BYTE_W-1:0] base);
    if (narrow)
      return base ^ bss_pkg::BYTE_W'($urandom_range(0, 3));
    return bss_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send(input logic [bss_pkg::OPCODE_W-1:0] op,
                      input logic [bss_pkg::BYTE_W-1:0] b);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bss_pkg::IN_TDATA_W-bss_pkg::OPCODE_W-bss_pkg::BYTE_W){1'b0}}, b, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // build a pattern, then run a few searches over haystacks that may carry it
  task automatic search_set();
    logic [bss_pkg::BYTE_W-1:0] pat [48];
    logic [bss_pkg::BYTE_W-1:0] base;
    logic [bss_pkg::BYTE_W-1:0] b;
    bit                         narrow;
    int                         plen, used, hlen, at, r, searches;
    narrow = ($urandom_range(0, 3) != 0);
    base   = bss_pkg::BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0)
      send(bss_pkg::OP_CLEAR, bss_pkg::BYTE_W'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 70)
      plen = $urandom_range(1, 4);
    else if (r < 90)
      plen = $urandom_range(5, 12);
    else if (r < 96)
      plen = $urandom_range(13, 32);
    else
      plen = $urandom_range(33, 40);
    for (int k = 0; k < plen; k++) begin
      pat[k] = pick_byte(narrow, base);
      send(bss_pkg::OP_APPEND, pat[k]);
    end
    used = (plen > bss_pkg::MAX_PATTERN_DEF) ? bss_pkg::MAX_PATTERN_DEF : plen;
    searches = $urandom_range(1, 3);
    repeat (searches) begin
      hlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      at = -1;
      if ($urandom_range(0, 1) && hlen >= used)
        at = $urandom_range(0, hlen - used);
      for (int k = 0; k < hlen; k++) begin
        b = (at >= 0 && k >= at && k < at + used) ? pat[k-at] : pick_byte(narrow, base);
        send(bss_pkg::OP_FEED, b);
      end
      send(bss_pkg::OP_FINISH, bss_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern, with and without haystack
    send(bss_pkg::OP_FINISH, 8'h00);
    send(bss_pkg::OP_FEED, 8'h00);
    send(bss_pkg::OP_FINISH, 8'hFF);
    // two-byte pattern at the byte extremes
    send(bss_pkg::OP_APPEND, 8'h00);
    send(bss_pkg::OP_APPEND, 8'hFF);
    send(bss_pkg::OP_FEED, 8'hFF);
    send(bss_pkg::OP_FEED, 8'h00);
    send(bss_pkg::OP_FEED, 8'hFF);
    send(bss_pkg::OP_FINISH, 8'h00);
    // haystack shorter than the pattern
    send(bss_pkg::OP_FEED, 8'h00);
    send(bss_pkg::OP_FINISH, 8'h00);
    // pattern grows mid-haystack
    send(bss_pkg::OP_FEED, 8'h00);
    send(bss_pkg::OP_APPEND, 8'h55);
    send(bss_pkg::OP_FEED, 8'h00);
    send(bss_pkg::OP_FEED, 8'hFF);
    send(bss_pkg::OP_FEED, 8'h55);
    send(bss_pkg::OP_FINISH, 8'h00);
    // single-byte pattern
    send(bss_pkg::OP_CLEAR, 8'hFF);
    send(bss_pkg::OP_APPEND, 8'hAA);
    send(bss_pkg::OP_FEED, 8'h55);
    send(bss_pkg::OP_FEED, 8'hAA);
    send(bss_pkg::OP_FINISH, 8'hFF);
    send(bss_pkg::OP_CLEAR, 8'h00);

    while (sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        search_set();
      end else begin
        repeat ($urandom_range(1, 8))
          send(bss_pkg::OPCODE_W'($urandom_range(0, 3)),
               bss_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
    burst = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
